// ===== rtl/core/fmgi_pkg.sv =====
// Shared types, codes and constants of the field map grid interpolator.
// No dependencies; every other file of the block but fmgi_ram imports this package.
`default_nettype none

package fmgi_pkg;

   localparam int GRID_NX_DEFAULT = 32;
   localparam int GRID_NY_DEFAULT = 32;
   localparam int GRID_NZ_DEFAULT = 64;

   localparam int MAP_DEPTH   = 65536;
   localparam int ADDR_W      = 16;
   localparam int SAMPLE_W    = 24;
   localparam int COORD_W     = 32;
   localparam int SPACING_W   = 31;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUOT_W      = 24;
   localparam int DIV_STAGES  = QUOT_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int ENTRY_W     = 3 * SAMPLE_W;

   localparam int REQ_DATA_W = ADDR_W + 3 * SAMPLE_W + 3 * COORD_W;
   localparam int RSP_DATA_W = 3 * SAMPLE_W;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] STATUS_WRITTEN = 2'd0;
   localparam logic [1:0] STATUS_VALID   = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic [1:0] MODE_BLEND   = 2'd0;
   localparam logic [1:0] MODE_NEAREST = 2'd1;
   localparam logic [1:0] MODE_MEAN    = 2'd2;
   localparam logic [1:0] MODE_NONE    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_X_ORIGIN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_ORIGIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_ORIGIN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_X_SPACING = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_Y_SPACING = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_SPACING = 3'd6;

   typedef struct packed {
      logic [1:0]                      mode;
      logic [2:0][COORD_W-1:0]         origin;
      logic [2:0][SPACING_W-1:0]       spacing;
   } cfg_type;

   typedef struct packed {
      logic                            is_write;
      logic                            outside;
      logic [1:0]                      mode;
      logic [ADDR_W-1:0]               addr;
      logic [2:0][SAMPLE_W-1:0]        sample;
      logic [2:0][COORD_W-1:0]         offset;
   } item_type;

   typedef struct packed {
      logic                            is_write;
      logic                            outside;
      logic [1:0]                      mode;
      logic [ADDR_W-1:0]               addr;
      logic [2:0][SAMPLE_W-1:0]        sample;
   } tag_type;

   typedef struct packed {
      logic [1:0]                      status;
      logic [2:0][SAMPLE_W-1:0]        field;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/fmgi_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fmgi_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fmgi_front.sv =====
// Front end: unpacks a request word and classifies it (write, query, early outside).
// Depends on fmgi_pkg.
`default_nettype none

module fmgi_front (
   input  wire logic                          req_tuser,
   input  wire logic [fmgi_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire fmgi_pkg::cfg_type             cfg,
   output fmgi_pkg::item_type                 item
);
   import fmgi_pkg::*;

   logic [2:0][COORD_W-1:0] point;
   logic signed [COORD_W:0] diff [3];
   logic                    negative;

   always_comb begin
      point[0] = req_tdata[ADDR_W+3*SAMPLE_W +: COORD_W];
      point[1] = req_tdata[ADDR_W+3*SAMPLE_W+COORD_W +: COORD_W];
      point[2] = req_tdata[ADDR_W+3*SAMPLE_W+2*COORD_W +: COORD_W];
      negative = 1'b0;
      for (int a = 0; a < 3; a++) begin
         diff[a] = $signed({point[a][COORD_W-1], point[a]})
                 - $signed({cfg.origin[a][COORD_W-1], cfg.origin[a]});
         item.offset[a] = diff[a][COORD_W-1:0];
         negative = negative | diff[a][COORD_W];
      end
      item.is_write  = (req_tuser == CMD_WRITE);
      item.outside   = negative || (cfg.mode == MODE_NONE);
      item.mode      = cfg.mode;
      item.addr      = req_tdata[ADDR_W-1:0];
      item.sample[0] = req_tdata[ADDR_W +: SAMPLE_W];
      item.sample[1] = req_tdata[ADDR_W+SAMPLE_W +: SAMPLE_W];
      item.sample[2] = req_tdata[ADDR_W+2*SAMPLE_W +: SAMPLE_W];
   end

endmodule

`default_nettype wire

// ===== rtl/core/fmgi_queue.sv =====
// Short queue of classified words between the front end and the back end.
// Depends on fmgi_pkg.
`default_nettype none

module fmgi_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire fmgi_pkg::item_type push_item,
   input  wire logic               pop,
   output fmgi_pkg::item_type      head,
   output logic                    empty,
   output logic                    full
);
   import fmgi_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]         count_ff, count_in;

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == (PtrW+1)'(QUEUE_DEPTH));
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fmgi_div.sv =====
// Pipelined restoring divider, one quotient bit a stage: floor(offset * 2^16 / spacing).
// Depends on fmgi_pkg. Flags overflow when the quotient would not fit QUOT_W bits.
`default_nettype none

module fmgi_div (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [fmgi_pkg::COORD_W-1:0]   offset,
   input  wire logic [fmgi_pkg::SPACING_W-1:0] spacing,
   output logic      [fmgi_pkg::QUOT_W-1:0]    quotient,
   output logic      [fmgi_pkg::SPACING_W-1:0] remainder,
   output logic                                overflow
);
   import fmgi_pkg::*;

   logic [SPACING_W-1:0] rem_ff  [DIV_STAGES];
   logic [QUOT_W-1:0]    quot_ff [DIV_STAGES];
   logic [QUOT_W-1:0]    feed_ff [DIV_STAGES];
   logic                 ovf_ff  [DIV_STAGES];

   logic [SPACING_W-1:0] rem_src  [DIV_STAGES];
   logic [QUOT_W-1:0]    quot_src [DIV_STAGES];
   logic [QUOT_W-1:0]    feed_src [DIV_STAGES];
   logic                 ovf_src  [DIV_STAGES];
   logic [SPACING_W:0]   trial    [DIV_STAGES];
   logic                 fits     [DIV_STAGES];

   always_comb begin
      rem_src[0]  = SPACING_W'(offset[COORD_W-1:8]);
      quot_src[0] = '0;
      feed_src[0] = {offset[7:0], 16'h0000};
      ovf_src[0]  = SPACING_W'(offset[COORD_W-1:8]) >= spacing;
      for (int k = 1; k < DIV_STAGES; k++) begin
         rem_src[k]  = rem_ff[k-1];
         quot_src[k] = quot_ff[k-1];
         feed_src[k] = feed_ff[k-1];
         ovf_src[k]  = ovf_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         trial[k] = {rem_src[k], feed_src[k][QUOT_W-1]};
         fits[k]  = trial[k] >= {1'b0, spacing};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k]  <= fits[k] ? SPACING_W'(trial[k] - {1'b0, spacing})
                                  : SPACING_W'(trial[k]);
            quot_ff[k] <= {quot_src[k][QUOT_W-2:0], fits[k]};
            feed_ff[k] <= {feed_src[k][QUOT_W-2:0], 1'b0};
            ovf_ff[k]  <= ovf_src[k];
         end
      end
   end

   assign quotient  = quot_ff[DIV_STAGES-1];
   assign remainder = rem_ff[DIV_STAGES-1];
   assign overflow  = ovf_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/fmgi_back.sv =====
// Back end: divides, forms corner addresses, reads the banked map and blends.
// Depends on fmgi_pkg, fmgi_div and fmgi_ram. All stages advance together.
`default_nettype none

module fmgi_back #(
   parameter int GRID_NX = fmgi_pkg::GRID_NX_DEFAULT,
   parameter int GRID_NY = fmgi_pkg::GRID_NY_DEFAULT,
   parameter int GRID_NZ = fmgi_pkg::GRID_NZ_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fmgi_pkg::cfg_type  cfg,
   input  wire fmgi_pkg::item_type head,
   input  wire logic               empty,
   output logic                    pop,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output fmgi_pkg::rsp_type       rsp
);
   import fmgi_pkg::*;

   localparam int NyNz = GRID_NY * GRID_NZ;

   function automatic int grid_dim(input int a);
      return (a == 0) ? GRID_NX : (a == 1) ? GRID_NY : GRID_NZ;
   endfunction

   typedef logic signed [SAMPLE_W-1:0] smp_type;
   typedef logic signed [SAMPLE_W+18:0] prod_type;

   function automatic prod_type blend_mul(input smp_type a, input smp_type b,
                                          input logic [16:0] t);
      logic signed [SAMPLE_W:0] diff;
      logic signed [17:0]       w;
      diff = $signed({b[SAMPLE_W-1], b}) - $signed({a[SAMPLE_W-1], a});
      w    = $signed({1'b0, t});
      return diff * w;
   endfunction

   function automatic smp_type blend_round(input smp_type a, input prod_type p);
      logic signed [SAMPLE_W+19:0] acc;
      acc = $signed({a, 16'h0000}) + p + 44'sd32768;
      return acc[SAMPLE_W+15:16];
   endfunction

   logic en;
   assign en  = !rsp_valid || rsp_ready;
   assign pop = en && !empty;

   // divider and its tag line
   logic [QUOT_W-1:0]    quot [3];
   logic [SPACING_W-1:0] rem  [3];
   logic                 ovf  [3];

   for (genvar a = 0; a < 3; a++) begin : g_div
      fmgi_div u_div (
         .clock     (clock),
         .en        (en),
         .offset    (head.offset[a]),
         .spacing   (cfg.spacing[a]),
         .quotient  (quot[a]),
         .remainder (rem[a]),
         .overflow  (ovf[a])
      );
   end

   tag_type head_tag;
   tag_type d_tag_ff   [DIV_STAGES];
   logic    d_valid_ff [DIV_STAGES];

   always_comb begin
      head_tag.is_write = head.is_write;
      head_tag.outside  = head.outside;
      head_tag.mode     = head.mode;
      head_tag.addr     = head.addr;
      head_tag.sample   = head.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) d_valid_ff[k] <= 1'b0;
      end else if (en) begin
         d_valid_ff[0] <= !empty;
         for (int k = 1; k < DIV_STAGES; k++) d_valid_ff[k] <= d_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_tag_ff[0] <= head_tag;
         for (int k = 1; k < DIV_STAGES; k++) d_tag_ff[k] <= d_tag_ff[k-1];
      end
   end

   // cell index, weight, nearest corner, base address
   logic [7:0]  idx      [3];
   logic [16:0] wt       [3];
   logic [2:0]  near_sel;
   logic        axis_out;
   logic [31:0] base_wide;

   always_comb begin
      axis_out = 1'b0;
      for (int a = 0; a < 3; a++) begin
         logic              upper;
         logic [QUOT_W-1:0] last_q;
         last_q = QUOT_W'((grid_dim(a) - 1) * 65536);
         upper = quot[a][QUOT_W-1:16] >= 8'(grid_dim(a) - 1);
         idx[a] = upper ? 8'(grid_dim(a) - 2) : quot[a][QUOT_W-1:16];
         wt[a]  = upper ? 17'h10000 : {1'b0, quot[a][15:0]};
         near_sel[2-a] = upper || quot[a][15];
         axis_out = axis_out || ovf[a] || (quot[a] > last_q)
                  || ((quot[a] == last_q) && (rem[a] != '0));
      end
      base_wide = 32'(idx[0]) * 32'(NyNz) + 32'(idx[1]) * 32'(GRID_NZ) + 32'(idx[2]);
   end

   logic              a_valid_ff;
   tag_type           a_tag_ff;
   logic [ADDR_W-1:0] a_base_ff;
   logic [16:0]       a_wt_ff  [3];
   logic [2:0]        a_sel_ff;
   logic              a_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= d_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_tag_ff  <= d_tag_ff[DIV_STAGES-1];
         a_base_ff <= base_wide[ADDR_W-1:0];
         a_wt_ff   <= wt;
         a_sel_ff  <= near_sel;
         a_out_ff  <= d_tag_ff[DIV_STAGES-1].outside || axis_out;
      end
   end

   // corner reads; writes land at the same stage to keep order
   logic [ADDR_W-1:0]  corner [8];
   logic [ENTRY_W-1:0] rd_data [8];
   logic               wr_en;

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         corner[k] = a_base_ff + ADDR_W'(((k >> 2) & 1) * NyNz
                                       + ((k >> 1) & 1) * GRID_NZ + (k & 1));
      end
   end

   assign wr_en = en && a_valid_ff && a_tag_ff.is_write;

   for (genvar j = 0; j < 4; j++) begin : g_bank
      fmgi_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (MAP_DEPTH)
      ) u_ram (
         .clock     (clock),
         .wr_en     (wr_en),
         .wr_addr   (a_tag_ff.addr),
         .wr_data   (a_tag_ff.sample),
         .rd_en     (en),
         .rd_addr_a (corner[2*j]),
         .rd_addr_b (corner[2*j+1]),
         .rd_data_a (rd_data[2*j]),
         .rd_data_b (rd_data[2*j+1])
      );
   end

   logic       b_valid_ff;
   tag_type    b_tag_ff;
   logic [16:0] b_wt_ff [3];
   logic [2:0] b_sel_ff;
   logic       b_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_tag_ff <= a_tag_ff;
         b_wt_ff  <= a_wt_ff;
         b_sel_ff <= a_sel_ff;
         b_out_ff <= a_out_ff;
      end
   end

   // z products, nearest corner, corner mean
   smp_type  m [8][3];
   prod_type zprod [4][3];
   smp_type  near_val [3];
   smp_type  mean_val [3];

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         for (int c = 0; c < 3; c++) begin
            m[k][c] = $signed(rd_data[k][c*SAMPLE_W +: SAMPLE_W]);
         end
      end
      for (int c = 0; c < 3; c++) begin
         logic signed [SAMPLE_W+2:0] sum;
         sum = '0;
         for (int k = 0; k < 8; k++) sum = sum + (SAMPLE_W+3)'(m[k][c]);
         sum = sum + 27'sd4;
         mean_val[c] = sum[SAMPLE_W+2:3];
         near_val[c] = m[b_sel_ff][c];
         for (int j = 0; j < 4; j++) begin
            zprod[j][c] = blend_mul(m[2*j][c], m[2*j+1][c], b_wt_ff[2]);
         end
      end
   end

   typedef struct packed {
      logic                       valid;
      logic                       is_write;
      logic                       outside;
      logic [1:0]                 mode;
      logic [16:0]                wt_x;
      logic [16:0]                wt_y;
      logic [2:0][SAMPLE_W-1:0]   near_val;
      logic [2:0][SAMPLE_W-1:0]   mean_val;
   } side_type;

   side_type c_side_ff, d_side_ff, e_side_ff, f_side_ff;
   side_type b_side;

   always_comb begin
      b_side.valid    = b_valid_ff;
      b_side.is_write = b_tag_ff.is_write;
      b_side.outside  = b_out_ff;
      b_side.mode     = b_tag_ff.mode;
      b_side.wt_x     = b_wt_ff[0];
      b_side.wt_y     = b_wt_ff[1];
      for (int c = 0; c < 3; c++) begin
         b_side.near_val[c] = near_val[c];
         b_side.mean_val[c] = mean_val[c];
      end
   end

   smp_type  c_za_ff   [4][3];
   prod_type c_zprod_ff [4][3];
   smp_type  d_zr_ff   [4][3];
   smp_type  e_ya_ff   [2][3];
   prod_type e_yprod_ff [2][3];
   smp_type  f_yr_ff   [2][3];
   smp_type  g_xa_ff   [3];
   prod_type g_xprod_ff [3];
   side_type g_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_side_ff.valid <= 1'b0;
         d_side_ff.valid <= 1'b0;
         e_side_ff.valid <= 1'b0;
         f_side_ff.valid <= 1'b0;
         g_side_ff.valid <= 1'b0;
      end else if (en) begin
         c_side_ff.valid <= b_side.valid;
         d_side_ff.valid <= c_side_ff.valid;
         e_side_ff.valid <= d_side_ff.valid;
         f_side_ff.valid <= e_side_ff.valid;
         g_side_ff.valid <= f_side_ff.valid;
      end
      if (en) begin
         c_side_ff[$bits(side_type)-2:0] <= b_side[$bits(side_type)-2:0];
         d_side_ff[$bits(side_type)-2:0] <= c_side_ff[$bits(side_type)-2:0];
         e_side_ff[$bits(side_type)-2:0] <= d_side_ff[$bits(side_type)-2:0];
         f_side_ff[$bits(side_type)-2:0] <= e_side_ff[$bits(side_type)-2:0];
         g_side_ff[$bits(side_type)-2:0] <= f_side_ff[$bits(side_type)-2:0];
         for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
               c_za_ff[j][c]    <= m[2*j][c];
               c_zprod_ff[j][c] <= zprod[j][c];
               d_zr_ff[j][c]    <= blend_round(c_za_ff[j][c], c_zprod_ff[j][c]);
            end
            for (int i = 0; i < 2; i++) begin
               e_ya_ff[i][c]    <= d_zr_ff[2*i][c];
               e_yprod_ff[i][c] <= blend_mul(d_zr_ff[2*i][c], d_zr_ff[2*i+1][c],
                                             d_side_ff.wt_y);
               f_yr_ff[i][c]    <= blend_round(e_ya_ff[i][c], e_yprod_ff[i][c]);
            end
            g_xa_ff[c]    <= f_yr_ff[0][c];
            g_xprod_ff[c] <= blend_mul(f_yr_ff[0][c], f_yr_ff[1][c], f_side_ff.wt_x);
         end
      end
   end

   // result select and output register
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in.status = STATUS_WRITTEN;
      rsp_in.field  = '0;
      if (!g_side_ff.is_write) begin
         if (g_side_ff.outside) begin
            rsp_in.status = STATUS_OUTSIDE;
         end else begin
            rsp_in.status = STATUS_VALID;
            for (int c = 0; c < 3; c++) begin
               case (g_side_ff.mode)
                  MODE_BLEND:   rsp_in.field[c] = blend_round(g_xa_ff[c], g_xprod_ff[c]);
                  MODE_NEAREST: rsp_in.field[c] = g_side_ff.near_val[c];
                  MODE_MEAN:    rsp_in.field[c] = g_side_ff.mean_val[c];
                  default:      rsp_in.field[c] = '0;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= g_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/field_map_grid_interpolator_top.sv =====
// Top level of the field map grid interpolator: CSRs, front end, queue, back end.
// Depends on fmgi_pkg, fmgi_front, fmgi_queue and fmgi_back.
//
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tuser cmd, tdata address/samples/point
// rsp      out        rsp_tvalid/rsp_tready  tuser status, tdata field x/y/z
// csr      in         csr_wr_en              csr_index, csr_wdata
//
// One word per cycle sustained while the output register is not held; a word's result
// passes through the 24-stage divider, the map read and the blend stages.
// A full back end stalls as one when the output register is held; the queue keeps
// req_tready high until it fills. Synchronous reset clears control only; the map
// is undefined until written and has no clearing pass.
`default_nettype none

module field_map_grid_interpolator_top #(
   parameter int GRID_NX = fmgi_pkg::GRID_NX_DEFAULT,
   parameter int GRID_NY = fmgi_pkg::GRID_NY_DEFAULT,
   parameter int GRID_NZ = fmgi_pkg::GRID_NZ_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // cmd
   input  wire logic                              req_tuser,
   // entry_address, sample_x, sample_y, sample_z, point_x, point_y, point_z
   input  wire logic [fmgi_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status
   output logic      [1:0]                        rsp_tuser,
   // field_x, field_y, field_z
   output logic      [fmgi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [fmgi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [fmgi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fmgi_pkg::*;

   cfg_type              cfg_ff;
   logic [SPACING_W-1:0] spacing_in;

   assign spacing_in = (csr_wdata[SPACING_W-1:0] == '0) ? SPACING_W'(1)
                                                        : csr_wdata[SPACING_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode    <= MODE_BLEND;
         cfg_ff.origin  <= '0;
         for (int a = 0; a < 3; a++) cfg_ff.spacing[a] <= SPACING_W'(65536);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MODE:      cfg_ff.mode       <= csr_wdata[1:0];
            REG_X_ORIGIN:  cfg_ff.origin[0]  <= csr_wdata;
            REG_Y_ORIGIN:  cfg_ff.origin[1]  <= csr_wdata;
            REG_Z_ORIGIN:  cfg_ff.origin[2]  <= csr_wdata;
            REG_X_SPACING: cfg_ff.spacing[0] <= spacing_in;
            REG_Y_SPACING: cfg_ff.spacing[1] <= spacing_in;
            REG_Z_SPACING: cfg_ff.spacing[2] <= spacing_in;
            default: ;
         endcase
      end
   end

   item_type front_item;
   item_type head;
   logic     q_empty;
   logic     q_full;
   logic     q_pop;
   rsp_type  rsp;

   fmgi_front u_front (
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .cfg       (cfg_ff),
      .item      (front_item)
   );

   assign req_tready = !q_full;

   fmgi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !q_full),
      .push_item (front_item),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   fmgi_back #(
      .GRID_NX (GRID_NX),
      .GRID_NY (GRID_NY),
      .GRID_NZ (GRID_NZ)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .empty     (q_empty),
      .pop       (q_pop),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.status;
   assign rsp_tdata = rsp.field;

endmodule

`default_nettype wire
